// ----- design/bitu_pkg.sv -----
// Package for the binary image thinning unit: item structs, sizes, state codes and the pass decision function.
// No dependencies.
package bitu_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [7:0] PIX_BG = 8'd255;
    localparam logic [7:0] PIX_FG = 8'd0;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_pixel;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITER,     // start of an iteration
        ST_SCAN,     // issue the read of the centre or of one neighbour
        ST_SCAN_WAIT,
        ST_SCAN_EVAL,
        ST_CLEAR,    // read mark
        ST_CLEAR_WAIT,
        ST_CLEAR_DO,
        ST_READ_WAIT,
        ST_OUT
    } state_t;

    // Neighbour decision for one pass kind. nb order: NW,N,NE,E,SE,S,SW,W.
    function automatic logic pass_mark(input logic [1:0] kind, input logic [7:0] nb);
        logic [3:0] nz;
        logic [3:0] zo;
        logic       p1, p2, p3, p4, p5, p6, p7, p8;
        nz = 4'd0;
        zo = 4'd0;
        {p1, p2, p3, p4, p5, p6, p7, p8} = {nb[0], nb[1], nb[2], nb[3],
                                           nb[4], nb[5], nb[6], nb[7]};
        for (int k = 0; k < 8; k++)
        begin
            nz = nz + {3'd0, nb[k]};
            if (!nb[k] && nb[(k + 1) % 8])
                zo = zo + 4'd1;
        end
        case (kind)
            2'd0: pass_mark = nz >= 4'd2 && nz <= 4'd6 && zo == 4'd1 &&
                              !(p2 & p4 & p6) && !(p4 & p6 & p8);
            2'd1: pass_mark = nz >= 4'd3 && nz <= 4'd6 && zo == 4'd1 &&
                              !(p2 & p4 & p8) && !(p2 & p6 & p8);
            default: pass_mark = (p1 & p8 & p6 & !p3) || (p3 & p4 & p6 & !p1) ||
                                 (p5 & p6 & p8 & !p3) || (p4 & p6 & p7 & !p1);
        endcase
    endfunction

endpackage

// ----- design/binary_image_thinning_unit.sv -----
// Top level of the binary image thinning unit.
// Depends on bitu_pkg and bitu_ram.
//
// Channel  Direction  Handshake         Payload
// in       into       in_valid/in_stall in_item  (req_type, pixel_value)
// out      out of     out_valid/stall   out_item (pixel_out, last_pixel)
// cfg      into       cfg_we            cfg_index, cfg_data
//
// A load is taken in ST_IDLE, so loads can follow back to back until the final pixel;
// a read passes through ST_READ_WAIT to ST_OUT and waits there on any output stall.
// The load of the final pixel starts the thinning sweeps: each pass scans every
// pixel with a centre read of the single-port pixel plane, then 8 neighbour reads
// when the centre is set, each through ST_SCAN, ST_SCAN_WAIT and ST_SCAN_EVAL, then
// a clear sweep through ST_CLEAR, ST_CLEAR_WAIT and ST_CLEAR_DO for each pixel;
// three passes an iteration, repeated until an iteration removes nothing.
// Reset clears positions and the sequencer and sets both sizes to 256; the memories hold no reset.
// The input is stalled while an item or a sweep is in progress.
module binary_image_thinning_unit
    import bitu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bitu_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bitu_pkg::out_item_t   out_item,
    input  logic                  cfg_we,
    input  logic [bitu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bitu_pkg::CFG_W-1:0]     cfg_data
);
    import bitu_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 1;

    // Configuration and effective sizes.
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [XW-1:0]    w_eff;
    logic [YW-1:0]    h_eff;
    logic [PW-1:0]    n_pix;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = XW'(1);
        else if ({{(XW > CFG_W ? XW - CFG_W : 0){1'b0}}, width_reg} > MAX_WIDTH)
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(width_reg);
        if (height_reg == '0)
            h_eff = YW'(1);
        else if ({{(YW > CFG_W ? YW - CFG_W : 0){1'b0}}, height_reg} > MAX_HEIGHT)
            h_eff = YW'(MAX_HEIGHT);
        else
            h_eff = YW'(height_reg);
    end

    // Frame size follows the size registers at once, so an item right after a write sees it.
    assign n_pix = PW'(w_eff) * PW'(h_eff);

    state_t state_reg, state_next;
    logic [PW-1:0] load_pos_reg, read_pos_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [PW-1:0] idx_reg;
    logic [1:0]    kind_reg;
    logic [2:0]    nb_sel_reg;
    logic [6:0]    nb_reg;
    logic          centre_reg;
    logic          removed_reg;
    logic          out_valid_reg;
    out_item_t     out_item_reg;
    logic          last_reg;

    // Memory ports.
    logic          pl_we, pl_wd, pl_rd;
    logic [AW-1:0] pl_addr;
    logic          mk_we, mk_wd, mk_rd;
    logic [AW-1:0] mk_addr;

    bitu_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_plane (
        .clk(clk), .we(pl_we), .addr(pl_addr), .wdata(pl_wd), .rdata(pl_rd));
    bitu_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
        .clk(clk), .we(mk_we), .addr(mk_addr), .wdata(mk_wd), .rdata(mk_rd));

    // Neighbour offsets: select 0 is the centre, 1..8 NW..W. Fetch centre first.
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic                 n_out;
    logic [3:0]           fetch_sel;
    logic signed [PW+1:0] n_addr;

    // nb_sel_reg with centre_done flag: fetch_sel = 0 centre, else neighbour.
    logic centre_done_reg;
    assign fetch_sel = centre_done_reg ? {1'b0, nb_sel_reg} + 4'd1 : 4'd0;

    always_comb
    begin
        nx = $signed({2'b00, x_reg});
        ny = $signed({2'b00, y_reg});
        case (fetch_sel)
            4'd1: begin nx = nx - 1; ny = ny - 1; end
            4'd2: begin ny = ny - 1; end
            4'd3: begin nx = nx + 1; ny = ny - 1; end
            4'd4: begin nx = nx + 1; end
            4'd5: begin nx = nx + 1; ny = ny + 1; end
            4'd6: begin ny = ny + 1; end
            4'd7: begin nx = nx - 1; ny = ny + 1; end
            4'd8: begin nx = nx - 1; end
            default: ;
        endcase
        n_out = nx < 0 || ny < 0 || nx >= $signed({2'b00, w_eff})
             || ny >= $signed({2'b00, h_eff});
        // Row step of +-w from the current index; column step of +-1.
        n_addr = $signed({2'b00, idx_reg}) + (nx - $signed({2'b00, x_reg}));
        if (ny < $signed({2'b00, y_reg}))
            n_addr = n_addr - $signed({2'b00, w_eff});
        else if (ny > $signed({2'b00, y_reg}))
            n_addr = n_addr + $signed({2'b00, w_eff});
    end

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;

    logic [PW-1:0] load_pos_eff, read_pos_eff;
    assign load_pos_eff = load_pos_reg >= n_pix ? '0 : load_pos_reg;
    assign read_pos_eff = read_pos_reg >= n_pix ? '0 : read_pos_reg;

    logic nb_in;
    assign nb_in = n_out ? 1'b0 : pl_rd;
    logic last_pix_of_frame;
    assign last_pix_of_frame = idx_reg == n_pix - PW'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept_in)
                begin
                    if (in_item.req_type == REQ_READ)
                        state_next = ST_READ_WAIT;
                    else if (load_pos_eff + PW'(1) >= n_pix)
                        state_next = ST_ITER;
                end
            ST_ITER:       state_next = ST_SCAN;
            ST_SCAN:       state_next = ST_SCAN_WAIT;
            ST_SCAN_WAIT:  state_next = ST_SCAN_EVAL;
            ST_SCAN_EVAL:
                if ((!centre_done_reg && !pl_rd) || (centre_done_reg && nb_sel_reg == 3'd7))
                    state_next = last_pix_of_frame ? ST_CLEAR : ST_SCAN;
                else
                    state_next = ST_SCAN;
            ST_CLEAR:      state_next = ST_CLEAR_WAIT;
            ST_CLEAR_WAIT: state_next = ST_CLEAR_DO;
            ST_CLEAR_DO:
                if (!last_pix_of_frame)
                    state_next = ST_CLEAR;
                else if (kind_reg != 2'd2)
                    state_next = ST_SCAN;
                else if (removed_reg || mk_rd)
                    state_next = ST_ITER;
                else
                    state_next = ST_IDLE;
            ST_READ_WAIT:  state_next = ST_OUT;
            ST_OUT:        state_next = out_stall ? ST_OUT : ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Memory port drive.
    always_comb
    begin
        pl_we   = 1'b0;
        pl_wd   = 1'b0;
        pl_addr = idx_reg[AW-1:0];
        mk_we   = 1'b0;
        mk_wd   = 1'b0;
        mk_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && in_item.req_type == REQ_LOAD)
                begin
                    pl_we   = 1'b1;
                    pl_wd   = in_item.pixel_value == 8'd0;
                    pl_addr = load_pos_eff[AW-1:0];
                end
                else
                    pl_addr = read_pos_eff[AW-1:0];
            end
            ST_SCAN, ST_SCAN_WAIT:
                // Hold the neighbour address until its data is evaluated.
                pl_addr = n_addr[AW-1:0];
            ST_SCAN_EVAL:
            begin
                // Write the mark once the pixel is decided.
                if (!centre_done_reg && !pl_rd)
                begin
                    mk_we = 1'b1;
                    mk_wd = 1'b0;
                end
                else if (centre_done_reg && nb_sel_reg == 3'd7)
                begin
                    mk_we = 1'b1;
                    mk_wd = pass_mark(kind_reg, {nb_in, nb_reg[6:0]});
                end
            end
            ST_CLEAR_DO:
                if (mk_rd)
                begin
                    pl_we = 1'b1;
                    pl_wd = 1'b0;
                end
            default: ;
        endcase
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            width_reg       <= CFG_W'(256);
            height_reg      <= CFG_W'(256);
            load_pos_reg    <= '0;
            read_pos_reg    <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            idx_reg         <= '0;
            kind_reg        <= '0;
            nb_sel_reg      <= '0;
            centre_done_reg <= 1'b0;
            removed_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
                load_pos_reg <= '0;
                read_pos_reg <= '0;
            end
            unique case (state_reg)
                ST_IDLE:
                    if (accept_in)
                    begin
                        if (in_item.req_type == REQ_LOAD)
                            load_pos_reg <= (load_pos_eff + PW'(1) >= n_pix) ? '0
                                          : load_pos_eff + PW'(1);
                        else
                        begin
                            last_reg     <= read_pos_eff == n_pix - PW'(1);
                            read_pos_reg <= (read_pos_eff + PW'(1) >= n_pix) ? '0
                                          : read_pos_eff + PW'(1);
                        end
                        if (in_item.req_type == REQ_LOAD &&
                            load_pos_eff + PW'(1) >= n_pix)
                            read_pos_reg <= '0;
                    end
                ST_ITER:
                begin
                    removed_reg     <= 1'b0;
                    kind_reg        <= 2'd0;
                    x_reg           <= '0;
                    y_reg           <= '0;
                    idx_reg         <= '0;
                    centre_done_reg <= 1'b0;
                    nb_sel_reg      <= '0;
                end
                ST_SCAN_EVAL:
                begin
                    if (!centre_done_reg && pl_rd)
                        centre_done_reg <= 1'b1;
                    else if (centre_done_reg && nb_sel_reg != 3'd7)
                    begin
                        nb_reg[nb_sel_reg] <= nb_in;
                        nb_sel_reg         <= nb_sel_reg + 3'd1;
                    end
                    else
                    begin
                        // Pixel done: advance raster position or start clearing.
                        centre_done_reg <= 1'b0;
                        nb_sel_reg      <= '0;
                        if (last_pix_of_frame)
                        begin
                            x_reg   <= '0;
                            y_reg   <= '0;
                            idx_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + PW'(1);
                            if (x_reg == w_eff - XW'(1))
                            begin
                                x_reg <= '0;
                                y_reg <= y_reg + YW'(1);
                            end
                            else
                                x_reg <= x_reg + XW'(1);
                        end
                    end
                end
                ST_CLEAR_DO:
                begin
                    if (mk_rd)
                        removed_reg <= 1'b1;
                    if (last_pix_of_frame)
                    begin
                        idx_reg  <= '0;
                        kind_reg <= kind_reg + 2'd1;
                    end
                    else
                        idx_reg <= idx_reg + PW'(1);
                end
                ST_READ_WAIT:
                    out_valid_reg <= 1'b1;
                ST_OUT:
                    if (!out_stall)
                        out_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Capture the read data as the output item.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ_WAIT)
        begin
            out_item_reg.pixel_out  <= pl_rd ? PIX_FG : PIX_BG;
            out_item_reg.last_pixel <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
endmodule

// ----- design/bitu_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module bitu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- dv/tb_binary_image_thinning_unit.sv -----
// Self-checking testbench for binary_image_thinning_unit: directed table, then random frames.
// Depends on bitu_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_binary_image_thinning_unit;
    import bitu_pkg::*;

    localparam int PLANE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int STALL_LIMIT = 1000000;  // cycles with nothing accepted
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LONG_HOLD = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    always #1 clk = ~clk;

    binary_image_thinning_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the pixel plane and positions.
    // ------------------------------------------------------------------
    bit          plane [PLANE_DEPTH];
    bit          marks [PLANE_DEPTH];
    bit          loaded [PLANE_DEPTH];   // entries ever written by a load
    logic [8:0]  width_reg = 9'd256;
    logic [8:0]  height_reg = 9'd256;
    int          load_pos = 0;
    int          read_pos = 0;
    int          sweep_pause = 0;       // cycles the block may still spend thinning

    out_item_t   pending_pixels [$];    // expected read results, oldest first
    int          failures = 0;
    int          sent_items = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;

    function automatic int eff_dim(logic [8:0] v, int maxv);
        if (v == 9'd0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic int frame_w();
        return eff_dim(width_reg, DEF_MAX_WIDTH);
    endfunction

    function automatic int frame_size();
        return eff_dim(width_reg, DEF_MAX_WIDTH) * eff_dim(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function automatic bit pixel_at(int x, int y, int w, int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        return plane[y * w + x];
    endfunction

    // One pass: mark against the image at pass start, then clear. Returns removals.
    function automatic int thin_pass(int kind, int w, int h);
        bit p [1:9];
        int nz;
        int zo;
        int removed;
        bit hit;
        removed = 0;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                marks[y * w + x] = 1'b0;
                if (!plane[y * w + x])
                    continue;
                p[1] = pixel_at(x - 1, y - 1, w, h);
                p[2] = pixel_at(x,     y - 1, w, h);
                p[3] = pixel_at(x + 1, y - 1, w, h);
                p[4] = pixel_at(x + 1, y,     w, h);
                p[5] = pixel_at(x + 1, y + 1, w, h);
                p[6] = pixel_at(x,     y + 1, w, h);
                p[7] = pixel_at(x - 1, y + 1, w, h);
                p[8] = pixel_at(x - 1, y,     w, h);
                p[9] = p[1];
                nz = 0;
                zo = 0;
                for (int k = 1; k <= 8; k++)
                begin
                    nz += p[k];
                    if (!p[k] && p[k + 1])
                        zo++;
                end
                if (kind == 0)
                    hit = nz >= 2 && nz <= 6 && zo == 1 &&
                          !(p[2] & p[4] & p[6]) && !(p[4] & p[6] & p[8]);
                else if (kind == 1)
                    hit = nz >= 3 && nz <= 6 && zo == 1 &&
                          !(p[2] & p[4] & p[8]) && !(p[2] & p[6] & p[8]);
                else
                    hit = (p[1] & p[8] & p[6] & !p[3]) || (p[3] & p[4] & p[6] & !p[1]) ||
                          (p[5] & p[6] & p[8] & !p[3]) || (p[4] & p[6] & p[7] & !p[1]);
                marks[y * w + x] = hit;
            end
        end
        for (int i = 0; i < w * h; i++)
        begin
            if (marks[i])
            begin
                plane[i] = 1'b0;
                removed++;
            end
        end
        return removed;
    endfunction

    // Thin the frame in place and note how long the block may take over it.
    task automatic thin_frame();
        int w;
        int h;
        int iters;
        bit any;
        w = frame_w();
        h = eff_dim(height_reg, DEF_MAX_HEIGHT);
        iters = 0;
        do
        begin
            any = 1'b0;
            for (int k = 0; k < 3; k++)
                if (thin_pass(k, w, h) != 0)
                    any = 1'b1;
            iters++;
        end
        while (any);
        sweep_pause = iters * 3 * 32 * w * h + 64;
    endtask

    // Apply one accepted item; returns 1 and the expected pixel for a read.
    task automatic apply_item(input in_item_t it, output bit has_pixel, output out_item_t px);
        int n;
        n = frame_size();
        has_pixel = 1'b0;
        px = '0;
        if (it.req_type == REQ_LOAD)
        begin
            if (load_pos >= n)
                load_pos = 0;
            plane[load_pos] = (it.pixel_value == 8'd0);
            loaded[load_pos] = 1'b1;
            load_pos++;
            if (load_pos >= n)
            begin
                thin_frame();
                load_pos = 0;
                read_pos = 0;
            end
        end
        else
        begin
            if (read_pos >= n)
                read_pos = 0;
            px.pixel_out = plane[read_pos] ? PIX_FG : PIX_BG;
            px.last_pixel = (read_pos == n - 1);
            has_pixel = 1'b1;
            read_pos++;
            if (read_pos >= n)
                read_pos = 0;
        end
    endtask

    // A read is legal only when the pixel it lands on has been loaded at some point.
    function automatic bit read_allowed();
        int rp;
        rp = (read_pos >= frame_size()) ? 0 : read_pos;
        return loaded[rp];
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item, with random idle cycles first; hold it until accepted.
    // Typed expectations, where given, replace the predicted pixel.
    task automatic send_item(input logic req, input logic [7:0] val,
                             input bit typed = 1'b0, input out_item_t typed_px = '0);
        in_item_t  it;
        bit        has_pixel;
        out_item_t px;
        it.req_type = req;
        it.pixel_value = val;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        apply_item(it, has_pixel, px);
        if (has_pixel)
            pending_pixels.push_back(typed ? typed_px : px);
        sent_items++;
    endtask

    // Drain, let any sweep finish, then write one register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (sweep_pause + 8) @(posedge clk);
        sweep_pause = 0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[8:0];
        else
            height_reg = value[8:0];
        load_pos = 0;
        read_pos = 0;
    endtask

    // Load a whole frame with random content, reads scattered in, then read it back.
    task automatic run_frame(input int w, input int h, input bit long_hold);
        int n;
        int fg_pct;
        int extra;
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        n = frame_size();
        fg_pct = $urandom_range(95, 20);
        for (int i = 0; i < n; i++)
        begin
            // occasional read while loading: returns whatever the plane holds
            if ($urandom_range(99) < 10 && read_allowed())
                send_item(REQ_READ, 8'($urandom));
            send_item(REQ_LOAD, ($urandom_range(99) < fg_pct) ? 8'd0 : 8'($urandom_range(255, 1)));
        end
        if (long_hold)
            hold_requests++;
        // full readout, sometimes running past the end so the position wraps
        extra = ($urandom_range(3) == 0) ? $urandom_range(n) : 0;
        for (int i = 0; i < n + extra; i++)
            send_item(REQ_READ, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, plus long hold-offs on request.
    // ------------------------------------------------------------------
    int hold_served = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %0d last_pixel %0d",
                       out_item.pixel_out, out_item.last_pixel);
                failures++;
            end
            else
            begin
                out_item_t want;
                want = pending_pixels.pop_front();
                if (out_item.pixel_out !== want.pixel_out)
                begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel_out, out_item.pixel_out);
                    failures++;
                end
                if (out_item.last_pixel !== want.last_pixel)
                begin
                    $error("last_pixel: expected %0d, got %0d",
                           want.last_pixel, out_item.last_pixel);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing has been accepted for too long.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;       // register for ROW_CFG
        logic                 req;       // request type for ROW_ITEM
        int                   data;      // register value or pixel value
        bit                   typed;     // expectation typed in below
        logic [7:0]           px;
        logic                 last;
    } stim_row_t;

    localparam int N_ROWS = 21;
    stim_row_t rows [N_ROWS];

    initial
    begin
        out_item_t typed_px;

        rows = '{
            // width and height of zero act as one: a single-pixel frame
            '{ROW_CFG,  REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_CFG,  REG_IMAGE_HEIGHT, REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            // an isolated pixel survives thinning
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_READ, 0,   1, PIX_FG, 1'b1},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 255, 0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_READ, 170, 1, PIX_BG, 1'b1},
            // read end wraps back to the first pixel
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_READ, 85,  1, PIX_BG, 1'b1},
            // solid 3x3 block
            '{ROW_CFG,  REG_IMAGE_WIDTH,  REQ_LOAD, 3,   0, PIX_FG, 1'b0},
            '{ROW_CFG,  REG_IMAGE_HEIGHT, REQ_LOAD, 3,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_LOAD, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_READ, 0,   0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_READ, 255, 0, PIX_FG, 1'b0},
            '{ROW_ITEM, REG_IMAGE_WIDTH,  REQ_READ, 0,   0, PIX_FG, 1'b0}
        };

        // hold reset low, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].data);
            else
            begin
                typed_px.pixel_out = rows[i].px;
                typed_px.last_pixel = rows[i].last;
                send_item(rows[i].req, 8'(rows[i].data), rows[i].typed, typed_px);
            end
        end

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            int goal;
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            goal = sent_items + ITEMS_PER_PHASE;
            if (phase == 0)
            begin
                // size extremes: zero width gives the tallest column, oversized
                // width clamps to the widest row
                run_frame(0, 256, 1'b0);
                run_frame(511, 1, 1'b0);
            end
            if (phase == 2)
                run_frame(5, 4, 1'b1);   // long hold-off so the input backs up
            while (sent_items < goal)
            begin
                if ($urandom_range(29) == 0)
                    run_frame($urandom_range(12, 8), $urandom_range(12, 8), 1'b0);
                else
                    run_frame($urandom_range(6, 1), $urandom_range(6, 1), 1'b0);
            end
        end

        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (sweep_pause + 20) @(posedge clk);

        if (failures == 0 && pending_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
